// ===== sv/kwp_pkg.sv =====
// Shared types, constants and helpers for the KMP word pattern search block.
package kwp_pkg;

  localparam int BYTE_W  = 8;
  localparam int INDEX_W = 5;
  localparam int OUT_W   = 16;

  localparam logic ACTION_PATTERN = 1'b0;
  localparam logic ACTION_TEXT    = 1'b1;

  localparam logic [BYTE_W-1:0] CHAR_SPACE = 8'd32;
  localparam logic [BYTE_W-1:0] CHAR_TAB   = 8'd9;
  localparam logic [BYTE_W-1:0] CHAR_CR    = 8'd13;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SEARCH,
    S_FINISH
  } kwp_state_t;

  // Whitespace separates words: space and the control codes tab through carriage return.
  function automatic logic is_blank(input logic [BYTE_W-1:0] c);
    return (c == CHAR_SPACE) || ((c >= CHAR_TAB) && (c <= CHAR_CR));
  endfunction

endpackage

// ===== sv/kwp_if.sv =====
// Valid/ready channel interfaces for input items and result items.
interface kwp_in_if;
  logic                        valid;
  logic                        ready;
  logic                        action;
  logic [kwp_pkg::BYTE_W-1:0]  data_byte;
  logic [kwp_pkg::INDEX_W-1:0] pattern_index;
  logic                        last;

  modport source (output valid, action, data_byte, pattern_index, last, input ready);
  modport sink   (input valid, action, data_byte, pattern_index, last, output ready);
endinterface

interface kwp_out_if;
  logic                       valid;
  logic                       ready;
  logic                       word_matched;
  logic [kwp_pkg::OUT_W-1:0]  match_count;
  logic [kwp_pkg::OUT_W-1:0]  word_start;
  logic [kwp_pkg::OUT_W-1:0]  word_length;
  logic                       text_done;

  modport source (output valid, word_matched, match_count, word_start, word_length, text_done,
                  input ready);
  modport sink   (input valid, word_matched, match_count, word_start, word_length, text_done,
                  output ready);
endinterface

// ===== sv/kwp_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module kwp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== sv/kwp_kmp_unit.sv =====
// Shared KMP step unit: pattern and failure stores plus the fallback loop.
module kwp_kmp_unit #(
  parameter int MAX_PATTERN = 32
) (
  input  logic                                            clk,
  input  logic                                            rst,
  input  logic                                            start,
  input  logic [$clog2(MAX_PATTERN+1)-1:0]                start_len,
  input  logic [kwp_pkg::BYTE_W-1:0]                      key,
  input  logic                                            pat_we,
  input  logic [(MAX_PATTERN > 1 ? $clog2(MAX_PATTERN) : 1)-1:0] pat_waddr,
  input  logic [kwp_pkg::BYTE_W-1:0]                      pat_wdata,
  input  logic                                            fail_we,
  input  logic [(MAX_PATTERN > 1 ? $clog2(MAX_PATTERN) : 1)-1:0] fail_waddr,
  input  logic [$clog2(MAX_PATTERN+1)-1:0]                fail_wdata,
  output logic                                            done,
  output logic [$clog2(MAX_PATTERN+1)-1:0]                result_len
);

  localparam int PW = $clog2(MAX_PATTERN + 1);
  localparam int AW = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;

  logic                        busy;
  logic [PW-1:0]               cur;
  logic [kwp_pkg::BYTE_W-1:0]  key_hold;
  logic [PW-1:0]               rd_len;
  logic [PW-1:0]               rd_len_m1;
  logic [kwp_pkg::BYTE_W-1:0]  pat_rdata;
  logic [PW-1:0]               fail_rdata;
  logic                        same;
  logic                        fall_back;

  // Issue the next probe: the start length, or the fallback target just read.
  always_comb begin
    rd_len    = start ? start_len : fail_rdata;
    rd_len_m1 = rd_len - PW'(1);
  end

  kwp_ram #(.WIDTH(kwp_pkg::BYTE_W), .DEPTH(MAX_PATTERN)) u_pat_ram (
    .clk   (clk),
    .we    (pat_we),
    .waddr (pat_waddr),
    .wdata (pat_wdata),
    .raddr (AW'(rd_len)),
    .rdata (pat_rdata)
  );

  kwp_ram #(.WIDTH(PW), .DEPTH(MAX_PATTERN)) u_fail_ram (
    .clk   (clk),
    .we    (fail_we),
    .waddr (fail_waddr),
    .wdata (fail_wdata),
    .raddr (AW'(rd_len_m1)),
    .rdata (fail_rdata)
  );

  assign same       = (pat_rdata == key_hold);
  assign fall_back  = busy && (cur != '0) && !same;
  assign done       = busy && !fall_back;
  assign result_len = same ? cur + PW'(1) : cur;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (start) begin
      busy <= 1'b1;
    end else if (done) begin
      busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      cur      <= start_len;
      key_hold <= key;
    end else if (fall_back) begin
      cur <= fail_rdata;
    end
  end

endmodule

// ===== sv/kmp_word_pattern_search.sv =====
// Top level of the KMP word pattern search block: sequencer, text state and result register.
//
// Usage: items arrive on text_in (valid/ready). A beat with action 0 loads a pattern
// byte: index 0 starts a new pattern and clears all text-side state; index equal to the
// current length appends a byte if room is left and extends the failure table; others drop.
// A beat with action 1 is a text byte. Whitespace (9 to 13, 32) separates words. Each word
// is searched with KMP until its first full match. When a word ends, or at the beat
// marked last, one result beat leaves on result_out with the match flag, the word's start
// offset and length, the running count of matching words and the end-of-text flag.
// Sequencing: a pattern restart completes in idle. A pattern append passes through search,
// a searched text byte through search and then finish; each failure-table fallback adds
// one probe, and each probe of the shared step unit reads the pattern and failure stores
// once through their registered read ports. A text byte that is not searched goes straight
// to finish. Amortized, a text byte costs under two probes. A result appears in the cycle
// after the finishing cycle and waits in the output register; the next item is accepted
// meanwhile, and only a following result waits while result_out stalls.
// Reset clears the pattern length, all text-side counters and the output valid flag; the
// pattern and failure stores hold no reset value and are read only below the length.
module kmp_word_pattern_search #(
  parameter int MAX_PATTERN = 32,
  parameter int COUNT_BITS  = 16
) (
  input logic      clk,
  input logic      rst,
  kwp_in_if.sink   text_in,
  kwp_out_if.source result_out
);

  localparam int PW = $clog2(MAX_PATTERN + 1);
  localparam int AW = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
  localparam int IW = (PW > kwp_pkg::INDEX_W) ? PW : kwp_pkg::INDEX_W;
  localparam int CW = COUNT_BITS;
  localparam int EW = (CW > kwp_pkg::OUT_W) ? CW : kwp_pkg::OUT_W;
  localparam logic [PW-1:0] PAT_MAX  = PW'(MAX_PATTERN);
  localparam logic [CW-1:0] CNT_MAX  = {CW{1'b1}};
  localparam logic [EW-1:0] OUT_LIMIT = EW'({kwp_pkg::OUT_W{1'b1}});

  // Clamp a counter to the 16-bit result fields.
  function automatic logic [kwp_pkg::OUT_W-1:0] clamp_out(input logic [CW-1:0] v);
    logic [EW-1:0] ext;
    ext = EW'(v);
    return (ext > OUT_LIMIT) ? {kwp_pkg::OUT_W{1'b1}} : ext[kwp_pkg::OUT_W-1:0];
  endfunction

  kwp_pkg::kwp_state_t state, state_next;

  // Pattern side
  logic [PW-1:0] pattern_length;
  logic [PW-1:0] build_prefix_length;

  // Text side
  logic [PW-1:0] match_position;
  logic          inside_word;
  logic          word_has_match;
  logic [CW-1:0] matching_words;
  logic [CW-1:0] text_offset;
  logic [CW-1:0] current_word_start;

  // Held item
  logic                        hold_build;
  logic                        hold_blank;
  logic                        hold_last;
  logic [kwp_pkg::INDEX_W-1:0] hold_pos;

  // Result register
  logic                       out_valid;
  logic                       out_matched;
  logic [kwp_pkg::OUT_W-1:0]  out_count;
  logic [kwp_pkg::OUT_W-1:0]  out_start;
  logic [kwp_pkg::OUT_W-1:0]  out_length;
  logic                       out_done;

  // Decode
  logic          accept;
  logic          in_blank;
  logic          acc_restart;
  logic          acc_append;
  logic          acc_text;
  logic          new_word;
  logic          has_match_eff;
  logic [PW-1:0] match_pos_eff;
  logic          text_search;
  logic          unit_start;
  logic [PW-1:0] unit_start_len;
  logic          unit_done;
  logic [PW-1:0] unit_len;
  logic          build_done;
  logic          text_step_done;
  logic          word_hit;
  logic          emit;
  logic          out_free;
  logic          finish;
  logic          fail_we;
  logic [AW-1:0] fail_waddr;
  logic [PW-1:0] fail_wdata;
  logic [CW-1:0] offset_inc;
  logic [CW-1:0] word_end;

  assign text_in.ready = (state == kwp_pkg::S_IDLE);
  assign accept        = text_in.valid && text_in.ready;
  assign in_blank      = kwp_pkg::is_blank(text_in.data_byte);

  // Pattern beats: a restart at index zero, or an in-order append while room is left.
  assign acc_restart = accept && (text_in.action == kwp_pkg::ACTION_PATTERN) &&
                       (text_in.pattern_index == '0);
  assign acc_append  = accept && (text_in.action == kwp_pkg::ACTION_PATTERN) &&
                       (text_in.pattern_index != '0) &&
                       (IW'(text_in.pattern_index) == IW'(pattern_length)) &&
                       (pattern_length < PAT_MAX);
  assign acc_text    = accept && (text_in.action == kwp_pkg::ACTION_TEXT);

  // A letter opens a word when none is open; the new word starts unmatched at position zero.
  assign new_word      = !inside_word;
  assign has_match_eff = new_word ? 1'b0 : word_has_match;
  assign match_pos_eff = new_word ? '0 : match_position;
  assign text_search   = acc_text && !in_blank && !has_match_eff && (pattern_length != '0);

  assign unit_start     = acc_append || text_search;
  assign unit_start_len = acc_append ? build_prefix_length : match_pos_eff;

  // The failure entry of a restart is zero; an append writes it when its walk ends.
  always_comb begin
    fail_we    = acc_restart || build_done;
    fail_waddr = build_done ? AW'(hold_pos) : '0;
    fail_wdata = build_done ? unit_len : '0;
  end

  kwp_kmp_unit #(.MAX_PATTERN(MAX_PATTERN)) u_kmp_unit (
    .clk        (clk),
    .rst        (rst),
    .start      (unit_start),
    .start_len  (unit_start_len),
    .key        (text_in.data_byte),
    .pat_we     (acc_restart || acc_append),
    .pat_waddr  (AW'(text_in.pattern_index)),
    .pat_wdata  (text_in.data_byte),
    .fail_we    (fail_we),
    .fail_waddr (fail_waddr),
    .fail_wdata (fail_wdata),
    .done       (unit_done),
    .result_len (unit_len)
  );

  assign build_done     = (state == kwp_pkg::S_SEARCH) && unit_done && hold_build;
  assign text_step_done = (state == kwp_pkg::S_SEARCH) && unit_done && !hold_build;
  assign word_hit       = unit_len >= pattern_length;

  // A blank closes an open word or ends the text; a letter reports only at the end of text.
  assign emit     = hold_blank ? (inside_word || hold_last) : hold_last;
  assign out_free = !out_valid || result_out.ready;
  assign finish   = (state == kwp_pkg::S_FINISH) && (!emit || out_free);

  assign offset_inc = (text_offset != CNT_MAX) ? text_offset + CW'(1) : text_offset;
  // A letter counts itself before the word length is taken; a blank does not.
  assign word_end   = hold_blank ? text_offset : offset_inc;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= kwp_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      kwp_pkg::S_IDLE: begin
        if (unit_start) begin
          state_next = kwp_pkg::S_SEARCH;
        end else if (acc_text) begin
          state_next = kwp_pkg::S_FINISH;
        end
      end
      kwp_pkg::S_SEARCH: begin
        if (build_done) begin
          state_next = kwp_pkg::S_IDLE;
        end else if (text_step_done) begin
          state_next = kwp_pkg::S_FINISH;
        end
      end
      kwp_pkg::S_FINISH: begin
        if (finish) begin
          state_next = kwp_pkg::S_IDLE;
        end
      end
      default: state_next = kwp_pkg::S_IDLE;
    endcase
  end

  // Hold the item fields the later steps need.
  always_ff @(posedge clk) begin
    if (accept) begin
      hold_build <= (text_in.action == kwp_pkg::ACTION_PATTERN);
      hold_blank <= in_blank;
      hold_last  <= text_in.last;
      hold_pos   <= text_in.pattern_index;
    end
  end

  // Pattern length and the prefix length carried between appends.
  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_length      <= '0;
      build_prefix_length <= '0;
    end else if (acc_restart) begin
      pattern_length      <= PW'(1);
      build_prefix_length <= '0;
    end else if (build_done) begin
      pattern_length      <= PW'(IW'(hold_pos) + IW'(1));
      build_prefix_length <= unit_len;
    end
  end

  // Text-side state.
  always_ff @(posedge clk) begin
    if (rst || acc_restart) begin
      match_position     <= '0;
      inside_word        <= 1'b0;
      word_has_match     <= 1'b0;
      matching_words     <= '0;
      text_offset        <= '0;
      current_word_start <= '0;
    end else if (acc_text && !in_blank && new_word) begin
      inside_word        <= 1'b1;
      current_word_start <= text_offset;
      match_position     <= '0;
      word_has_match     <= 1'b0;
    end else if (text_step_done) begin
      if (word_hit) begin
        word_has_match <= 1'b1;
        match_position <= '0;
        if (matching_words != CNT_MAX) begin
          matching_words <= matching_words + CW'(1);
        end
      end else begin
        match_position <= unit_len;
      end
    end else if (finish) begin
      if (hold_last) begin
        match_position     <= '0;
        inside_word        <= 1'b0;
        word_has_match     <= 1'b0;
        matching_words     <= '0;
        text_offset        <= '0;
        current_word_start <= '0;
      end else begin
        text_offset <= offset_inc;
        if (emit) begin
          inside_word    <= 1'b0;
          word_has_match <= 1'b0;
          match_position <= '0;
        end
      end
    end
  end

  // Result register: load on an emitting finish, drop once the beat is taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (finish && emit) begin
      out_valid <= 1'b1;
    end else if (result_out.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (finish && emit) begin
      out_matched <= inside_word && word_has_match;
      out_count   <= clamp_out(matching_words);
      out_start   <= clamp_out(inside_word ? current_word_start : text_offset);
      out_length  <= clamp_out(inside_word ? word_end - current_word_start : '0);
      out_done    <= hold_last;
    end
  end

  assign result_out.valid        = out_valid;
  assign result_out.word_matched = out_matched;
  assign result_out.match_count  = out_count;
  assign result_out.word_start   = out_start;
  assign result_out.word_length  = out_length;
  assign result_out.text_done    = out_done;

endmodule

// ===== tb/kwp_match_checker.sv =====
// Checker for the KMP word search: watches both channels, predicts each word report, compares.
`timescale 1ns / 1ps

module kwp_match_checker #(
  parameter int MAX_PATTERN = 32,
  parameter int COUNT_BITS  = 16
) (
  input  logic clk,
  input  logic rst,
  kwp_in_if    text_in,
  kwp_out_if   result_out,
  output int   errors,
  output int   pending
);

  localparam int BYTE_W  = kwp_pkg::BYTE_W;
  localparam int INDEX_W = kwp_pkg::INDEX_W;
  localparam int OUT_W   = kwp_pkg::OUT_W;

  localparam longint unsigned CNT_MAX = (64'd1 << COUNT_BITS) - 64'd1;
  localparam longint unsigned OUT_MAX = 64'd65535;

  typedef struct {
    logic             matched;
    logic [OUT_W-1:0] count;
    logic [OUT_W-1:0] start;
    logic [OUT_W-1:0] length;
    logic             done;
  } word_report_t;

  word_report_t owed_reports[$];

  logic [BYTE_W-1:0] pat_bytes [MAX_PATTERN];
  int unsigned       fallback  [MAX_PATTERN];
  int unsigned       pat_len;
  int unsigned       border_len;
  int unsigned       match_pos;
  bit                in_word;
  bit                word_hit;
  longint unsigned   words_found;
  longint unsigned   offset;
  longint unsigned   word_begin;

  int mismatches = 0;
  int owed_count = 0;

  assign errors  = mismatches;
  assign pending = owed_count;

  task automatic report_mismatch(input string what, input longint unsigned got,
                                 input longint unsigned want);
    $display("%0t: mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
    mismatches++;
  endtask

  function automatic bit is_separator(input logic [BYTE_W-1:0] c);
    return (c == kwp_pkg::CHAR_SPACE) ||
           ((c >= kwp_pkg::CHAR_TAB) && (c <= kwp_pkg::CHAR_CR));
  endfunction

  function automatic logic [OUT_W-1:0] clamp_out(input longint unsigned v);
    return (v > OUT_MAX) ? OUT_W'(OUT_MAX) : OUT_W'(v);
  endfunction

  task automatic clear_text();
    match_pos   = 0;
    in_word     = 1'b0;
    word_hit    = 1'b0;
    words_found = 0;
    offset      = 0;
    word_begin  = 0;
  endtask

  task automatic append_pattern(input int unsigned idx, input logic [BYTE_W-1:0] b);
    int unsigned k;
    if (idx == 0) begin
      pat_bytes[0] = b;
      fallback[0]  = 0;
      pat_len      = 1;
      border_len   = 0;
      clear_text();
      return;
    end
    if (idx != pat_len || pat_len >= MAX_PATTERN) return;
    pat_bytes[idx] = b;
    k = border_len;
    while (k > 0 && pat_bytes[k] != b) k = fallback[k-1];
    if (pat_bytes[k] == b) k++;
    fallback[idx] = k;
    border_len    = k;
    pat_len       = idx + 1;
  endtask

  task automatic scan_text_byte(input logic [BYTE_W-1:0] c);
    int unsigned k;
    if (word_hit || pat_len == 0) return;
    k = match_pos;
    while (k > 0 && pat_bytes[k] != c) k = fallback[k-1];
    if (pat_bytes[k] == c) k++;
    if (k >= pat_len) begin
      word_hit = 1'b1;
      if (words_found < CNT_MAX) words_found++;
      k = 0;
    end
    match_pos = k;
  endtask

  task automatic absorb_item(input logic act, input logic [BYTE_W-1:0] b,
                             input logic [INDEX_W-1:0] idx, input logic lst);
    word_report_t rpt;
    bit           blank;
    bit           emit;
    if (act == kwp_pkg::ACTION_PATTERN) begin
      append_pattern(int'(idx), b);
      return;
    end
    blank = is_separator(b);
    emit  = 1'b0;
    if (blank) begin
      emit = in_word || lst;
    end else begin
      if (!in_word) begin
        in_word    = 1'b1;
        word_begin = offset;
        match_pos  = 0;
        word_hit   = 1'b0;
      end
      scan_text_byte(b);
      if (offset < CNT_MAX) offset++;
      emit = lst;
    end
    if (emit) begin
      rpt.matched = in_word && word_hit;
      rpt.count   = clamp_out(words_found);
      rpt.start   = clamp_out(in_word ? word_begin : offset);
      rpt.length  = clamp_out(in_word ? offset - word_begin : 0);
      rpt.done    = lst;
      owed_reports.push_back(rpt);
      in_word   = 1'b0;
      word_hit  = 1'b0;
      match_pos = 0;
    end
    if (blank && offset < CNT_MAX) offset++;
    if (lst) clear_text();
  endtask

  always @(posedge clk) begin
    word_report_t want;
    if (rst) begin
      pat_len    = 0;
      border_len = 0;
      clear_text();
      owed_reports.delete();
    end else begin
      if (result_out.valid && result_out.ready) begin
        if (owed_reports.size() == 0) begin
          report_mismatch("result beat with nothing expected", 1, 0);
        end else begin
          want = owed_reports.pop_front();
          if (result_out.word_matched !== want.matched)
            report_mismatch("word_matched", result_out.word_matched, want.matched);
          if (result_out.match_count !== want.count)
            report_mismatch("match_count", result_out.match_count, want.count);
          if (result_out.word_start !== want.start)
            report_mismatch("word_start", result_out.word_start, want.start);
          if (result_out.word_length !== want.length)
            report_mismatch("word_length", result_out.word_length, want.length);
          if (result_out.text_done !== want.done)
            report_mismatch("text_done", result_out.text_done, want.done);
        end
      end
      if (text_in.valid && text_in.ready)
        absorb_item(text_in.action, text_in.data_byte, text_in.pattern_index, text_in.last);
    end
    owed_count <= owed_reports.size();
  end

endmodule

// ===== tb/kmp_word_pattern_search_tb.sv =====
// Testbench top for the KMP word search: clock, reset, stimulus, receiver stalls and verdict.
`timescale 1ns / 1ps

module kmp_word_pattern_search_tb;

  localparam int BYTE_W  = kwp_pkg::BYTE_W;
  localparam int INDEX_W = kwp_pkg::INDEX_W;

  localparam int MAX_PATTERN = 32;
  localparam int COUNT_BITS  = 16;
  localparam int RANDOM_ITEMS = 400;
  localparam logic [BYTE_W-1:0] CH_A = "a";

  logic clk;
  logic rst;

  kwp_in_if  text_in ();
  kwp_out_if result_out ();

  int errors;
  int pending;

  // quiet: no sender gaps and no receiver stalls
  bit quiet;
  int ready_run;
  int burst_left;
  int loaded_len;
  int items_sent;

  kmp_word_pattern_search #(
    .MAX_PATTERN (MAX_PATTERN),
    .COUNT_BITS  (COUNT_BITS)
  ) u_dut (
    .clk        (clk),
    .rst        (rst),
    .text_in    (text_in),
    .result_out (result_out)
  );

  kwp_match_checker #(
    .MAX_PATTERN (MAX_PATTERN),
    .COUNT_BITS  (COUNT_BITS)
  ) u_check (
    .clk        (clk),
    .rst        (rst),
    .text_in    (text_in),
    .result_out (result_out),
    .errors     (errors),
    .pending    (pending)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // Receiver: alternate short open and stalled runs, with a long open stretch now and then.
  always @(posedge clk) begin
    if (rst) begin
      result_out.ready <= 1'b0;
      ready_run        <= 0;
    end else if (quiet) begin
      result_out.ready <= 1'b1;
    end else if (ready_run != 0) begin
      ready_run <= ready_run - 1;
    end else if (result_out.ready) begin
      result_out.ready <= 1'b0;
      ready_run        <= $urandom_range(0, 5);
    end else begin
      result_out.ready <= 1'b1;
      ready_run        <= ($urandom_range(0, 7) == 0) ? 60 : $urandom_range(0, 6);
    end
  end

  // Drive one beat and hold it until the block takes it. Between bursts drop valid
  // for a random gap; a burst that runs straight into the next beat keeps valid high.
  task automatic send_item(input logic act, input logic [BYTE_W-1:0] b,
                           input logic [INDEX_W-1:0] idx, input logic lst);
    text_in.valid         <= 1'b1;
    text_in.action        <= act;
    text_in.data_byte     <= b;
    text_in.pattern_index <= idx;
    text_in.last          <= lst;
    do @(posedge clk); while (!text_in.ready);
    items_sent++;
    if (burst_left > 0) begin
      burst_left--;
    end else if (!quiet) begin
      text_in.valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
      burst_left = ($urandom_range(0, 5) == 0) ? 50 : $urandom_range(0, 12);
    end
  endtask

  // Track the pattern length only to aim appends at the next free index.
  task automatic send_pattern(input int idx, input logic [BYTE_W-1:0] b, input logic lst);
    if (idx == 0) loaded_len = 1;
    else if (idx == loaded_len && loaded_len < MAX_PATTERN) loaded_len++;
    send_item(kwp_pkg::ACTION_PATTERN, b, INDEX_W'(idx), lst);
  endtask

  // The index field means nothing on a text beat; toggle it anyway.
  task automatic send_text(input logic [BYTE_W-1:0] b, input logic lst);
    send_item(kwp_pkg::ACTION_TEXT, b, INDEX_W'($urandom_range(0, 31)), lst);
  endtask

  // Hold off until every owed word report has come back.
  task automatic pause_until_drained();
    text_in.valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  function automatic logic [BYTE_W-1:0] blank_char();
    int r;
    r = $urandom_range(0, 5);
    return (r == 5) ? kwp_pkg::CHAR_SPACE : kwp_pkg::CHAR_TAB + BYTE_W'(r);
  endfunction

  // Mostly letters from a small alphabet so words actually hit the pattern.
  function automatic logic [BYTE_W-1:0] word_char();
    logic [BYTE_W-1:0] c;
    if ($urandom_range(0, 3) != 0) return CH_A + BYTE_W'($urandom_range(0, 2));
    do c = BYTE_W'($urandom_range(0, 255));
    while ((c == kwp_pkg::CHAR_SPACE) ||
           ((c >= kwp_pkg::CHAR_TAB) && (c <= kwp_pkg::CHAR_CR)));
    return c;
  endfunction

  // New pattern: mostly short, sometimes long up to full, with stray out-of-order bytes.
  task automatic load_random_pattern();
    int len;
    int stray;
    logic [BYTE_W-1:0] b;
    len = ($urandom_range(0, 5) == 0) ? $urandom_range(7, MAX_PATTERN) : $urandom_range(1, 4);
    for (int i = 0; i < len; i++) begin
      if (i > 0 && $urandom_range(0, 9) == 0) begin
        do stray = $urandom_range(1, 31); while (stray == i);
        send_pattern(stray, BYTE_W'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
      end
      b = ($urandom_range(0, 7) == 0) ? BYTE_W'($urandom_range(0, 255))
                                      : CH_A + BYTE_W'($urandom_range(0, 2));
      send_pattern(i, b, 1'($urandom_range(0, 1)));
    end
    // a full pattern must drop any further append
    if (len == MAX_PATTERN)
      send_pattern($urandom_range(1, 31), BYTE_W'($urandom_range(0, 255)), 1'b1);
  endtask

  // A run of words with random separators; usually closed by a last beat.
  task automatic send_sentence();
    int words;
    int wlen;
    int ending;
    words = $urandom_range(1, 6);
    for (int w = 0; w < words; w++) begin
      repeat ($urandom_range(0, 2)) send_text(blank_char(), 1'b0);
      wlen = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40) : $urandom_range(0, 7);
      for (int i = 0; i < wlen; i++) begin
        // extend the pattern mid-word now and then
        if (loaded_len < MAX_PATTERN && $urandom_range(0, 19) == 0)
          send_pattern(loaded_len, word_char(), 1'($urandom_range(0, 1)));
        send_text(word_char(), 1'b0);
      end
      send_text(blank_char(), 1'b0);
    end
    ending = $urandom_range(0, 3);
    if (ending == 0) send_text(blank_char(), 1'b1);
    else if (ending == 1) send_text(word_char(), 1'b1);
    else if (ending == 2) send_text(blank_char(), 1'b1);
  endtask

  initial begin
    int random_goal;
    int waited;
    rst                   = 1'b1;
    quiet                 = 1'b0;
    burst_left            = 0;
    loaded_len            = 0;
    items_sent            = 0;
    text_in.valid         = 1'b0;
    text_in.action        = kwp_pkg::ACTION_TEXT;
    text_in.data_byte     = '0;
    text_in.pattern_index = '0;
    text_in.last          = 1'b0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Text with no pattern loaded: words report but never match.
    send_text("x", 1'b0);
    send_text(kwp_pkg::CHAR_SPACE, 1'b0);
    // Last beat on a blank with no open word: an empty report, text done.
    send_text(kwp_pkg::CHAR_SPACE, 1'b1);

    // Pattern "abab": stray index dropped, last flag on a pattern byte is harmless.
    send_pattern(0, "a", 1'b0);
    send_pattern(5, "q", 1'b0);
    send_pattern(1, "b", 1'b1);
    send_pattern(2, "a", 1'b0);
    send_pattern(3, "b", 1'b0);

    // "abaabab" needs a fallback before the full match; tab closes the word.
    send_text("a", 1'b0);
    send_text("b", 1'b0);
    send_text("a", 1'b0);
    send_text("a", 1'b0);
    send_text("b", 1'b0);
    send_text("a", 1'b0);
    send_text("b", 1'b0);
    send_text(kwp_pkg::CHAR_TAB, 1'b0);

    // Byte extremes and the neighbors of the whitespace range are word bytes.
    send_text(8'hFF, 1'b0);
    send_text(8'h00, 1'b0);
    send_text(8'd8, 1'b0);
    send_text(8'd14, 1'b0);
    send_text(kwp_pkg::CHAR_CR, 1'b0);

    // Extend to "ababc" in the middle of an open word, then end the text on a space.
    send_text("a", 1'b0);
    send_text("b", 1'b0);
    send_pattern(4, "c", 1'b0);
    send_text("a", 1'b0);
    send_text("b", 1'b0);
    send_text("c", 1'b0);
    send_text(kwp_pkg::CHAR_SPACE, 1'b1);

    pause_until_drained();

    // Random part: mostly well-formed sentences, some new patterns, some noise.
    random_goal = items_sent + RANDOM_ITEMS;
    load_random_pattern();
    while (items_sent < random_goal) begin
      case ($urandom_range(0, 9))
        0: begin
          load_random_pattern();
        end
        1: begin
          repeat ($urandom_range(1, 4))
            send_item(1'($urandom_range(0, 1)), BYTE_W'($urandom_range(0, 255)),
                      INDEX_W'($urandom_range(0, 31)), 1'($urandom_range(0, 1)));
        end
        default: begin
          send_sentence();
        end
      endcase
      if ($urandom_range(0, 15) == 0) pause_until_drained();
      // toggle a stretch with no idling now and then
      if ($urandom_range(0, 9) == 0) quiet <= !quiet;
    end
    send_text(blank_char(), 1'b1);

    // Drain: wait for every owed report, then let the block settle.
    text_in.valid <= 1'b0;
    waited = 0;
    while (pending != 0 && waited < 100000) begin
      @(posedge clk);
      waited++;
    end
    repeat (64) @(posedge clk);
    if (errors == 0 && pending == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("timeout: block stopped making progress");
    $display("FAIL");
    $finish;
  end

endmodule
